### src/ptdm_pkg.sv
// shared types and constants for the periodic task deadline monitor
// no dependencies; imported by ptdm_div and periodic_task_deadline_monitor
`timescale 1ns / 1ps

package ptdm_pkg;

  localparam int TIME_W  = 32;  // tick, period, deadline, budget, miss count
  localparam int PROD_W  = 46;  // budget * 10000 fits in 46 bits
  localparam int UTIL_W  = 48;  // sum of up to four quotients
  localparam int BOUND_W = 14;

  localparam logic [BOUND_W-1:0] SCALE = 14'd10000;

  // request modes
  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_RELEASE  = 2'd1;
  localparam logic [1:0] MODE_CHECK    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_ZERO_PER   = 2'd2;
  localparam logic [1:0] ST_UNREG      = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // rate monotonic bound x10000 by task count
  function automatic logic [BOUND_W-1:0] rm_bound_of(input logic [2:0] n);
    logic [BOUND_W-1:0] b;
    case (n)
      3'd0:    b = 14'd0;
      3'd1:    b = 14'd10000;
      3'd2:    b = 14'd8284;
      3'd3:    b = 14'd7798;
      default: b = 14'd7568;
    endcase
    return b;
  endfunction

endpackage

### src/periodic_task_deadline_monitor.sv
// top level: task table, request sequencer and output register
// depends on ptdm_pkg and ptdm_div
`timescale 1ns / 1ps
// flow: mode 3 and failed register to result, register via REG_FIN,
//   release via REL_A/B, check via 46-step shared divider per task
// throughput: one word at a time; in_ready is low from accept until the
//   result is loaded into the output register, which may still be waiting
// reset: synchronous, clears task count, sequencer and out_valid; table
//   entries are only read once written

module periodic_task_deadline_monitor
  import ptdm_pkg::*;
#(
  parameter int MAX_TASKS = 4
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [1:0]         task_slot,
  input  logic [TIME_W-1:0]  now_tick,
  input  logic [TIME_W-1:0]  period,
  input  logic [TIME_W-1:0]  relative_deadline,
  input  logic [TIME_W-1:0]  exec_budget,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [1:0]         slot_out,
  output logic [TIME_W-1:0]  release_at,
  output logic [TIME_W-1:0]  absolute_deadline,
  output logic [TIME_W-1:0]  misses,
  output logic [UTIL_W-1:0]  utilization,
  output logic [BOUND_W-1:0] rm_bound,
  output logic               rm_ok,
  output logic               edf_ok
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REG_FIN,
    S_REL_A,
    S_REL_B,
    S_CHK_MUL,
    S_CHK_START,
    S_CHK_WAIT,
    S_CHK_FIN,
    S_RESULT
  } state_t;

  state_t state;

  // task table, one entry per slot
  logic [TIME_W-1:0] slot_period       [MAX_TASKS];
  logic [TIME_W-1:0] slot_deadline     [MAX_TASKS];
  logic [TIME_W-1:0] slot_budget       [MAX_TASKS];
  logic [TIME_W-1:0] next_release_time [MAX_TASKS];
  logic [TIME_W-1:0] miss_counter      [MAX_TASKS];

  logic [CNT_W-1:0]  task_count;
  logic [CNT_W-1:0]  idx;          // task walked by a check

  // captured request
  logic [1:0]        slot_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] cur_base;     // release of the current instance

  // result being built
  logic [1:0]         res_status;
  logic [1:0]         res_slot;
  logic [TIME_W-1:0]  res_release;
  logic [TIME_W-1:0]  res_abs;
  logic [TIME_W-1:0]  res_misses;
  logic [UTIL_W-1:0]  res_util;    // also the check accumulator
  logic [BOUND_W-1:0] res_bound;
  logic               res_rm_ok;
  logic               res_edf_ok;

  // shared divider
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] div_q;
  div_status_t       div_st;
  logic              div_start;

  // single table read port, address picked by sequencer state
  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] rd_period;
  logic [TIME_W-1:0] rd_deadline;
  logic [TIME_W-1:0] rd_budget;
  logic [TIME_W-1:0] rd_next;
  logic [TIME_W-1:0] rd_miss;

  logic              live_in;
  logic              has_room;
  logic              late;
  logic [TIME_W-1:0] miss_next;
  logic [BOUND_W-1:0] bound_now;

  always_comb begin
    case (state)
      S_IDLE:                               rd_idx = task_slot[IDX_W-1:0];
      S_CHK_MUL, S_CHK_START, S_CHK_WAIT:   rd_idx = idx[IDX_W-1:0];
      default:                              rd_idx = slot_q[IDX_W-1:0];
    endcase
  end

  assign rd_period   = slot_period[rd_idx];
  assign rd_deadline = slot_deadline[rd_idx];
  assign rd_budget   = slot_budget[rd_idx];
  assign rd_next     = next_release_time[rd_idx];
  assign rd_miss     = miss_counter[rd_idx];

  // a slot is live once registered; task_count never exceeds MAX_TASKS
  assign live_in   = {1'b0, task_slot} < 3'(task_count);
  assign has_room  = task_count < CNT_W'(MAX_TASKS);

  // miss test against the deadline of the instance being closed
  assign late      = now_q > (cur_base + rd_deadline);
  assign miss_next = rd_miss + TIME_W'(late);

  assign bound_now = rm_bound_of(3'(task_count));

  assign div_start = (state == S_CHK_START);
  assign in_ready  = (state == S_IDLE);

  ptdm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (rd_period),
    .quotient (div_q),
    .st       (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            slot_q      <= task_slot;
            now_q       <= now_tick;
            res_status  <= ST_OK;
            res_slot    <= task_slot;
            res_release <= '0;
            res_abs     <= '0;
            res_misses  <= live_in ? rd_miss : '0;
            res_util    <= '0;
            res_bound   <= '0;
            res_rm_ok   <= 1'b0;
            res_edf_ok  <= 1'b0;
            case (mode)
              MODE_REGISTER: begin
                if (!has_room) begin
                  // full test wins over zero period
                  res_status <= ST_FULL;
                  state      <= S_RESULT;
                end else if (period == '0) begin
                  res_status <= ST_ZERO_PER;
                  state      <= S_RESULT;
                end else begin
                  slot_period[task_count[IDX_W-1:0]]       <= period;
                  slot_deadline[task_count[IDX_W-1:0]]     <= relative_deadline;
                  slot_budget[task_count[IDX_W-1:0]]       <= exec_budget;
                  next_release_time[task_count[IDX_W-1:0]] <= now_tick + period;
                  miss_counter[task_count[IDX_W-1:0]]      <= '0;
                  task_count  <= task_count + CNT_W'(1);
                  slot_q      <= 2'(task_count);
                  res_slot    <= 2'(task_count);
                  res_release <= now_tick + period;
                  res_misses  <= '0;
                  state       <= S_REG_FIN;
                end
              end
              MODE_RELEASE: begin
                if (live_in) begin
                  state <= S_REL_A;
                end else begin
                  res_status <= ST_UNREG;
                  res_misses <= '0;
                  state      <= S_RESULT;
                end
              end
              MODE_CHECK: begin
                idx   <= '0;
                state <= S_CHK_MUL;
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_REG_FIN: begin
          res_abs <= res_release + rd_deadline;
          state   <= S_RESULT;
        end
        S_REL_A: begin
          cur_base    <= rd_next - rd_period;
          res_release <= rd_next;
          res_abs     <= rd_next + rd_deadline;
          state       <= S_REL_B;
        end
        S_REL_B: begin
          miss_counter[slot_q[IDX_W-1:0]]      <= miss_next;
          next_release_time[slot_q[IDX_W-1:0]] <= rd_next + rd_period;
          res_misses <= miss_next;
          state      <= S_RESULT;
        end
        S_CHK_MUL: begin
          if (idx == task_count) begin
            state <= S_CHK_FIN;
          end else if (rd_period == '0) begin
            idx <= idx + CNT_W'(1);
          end else begin
            prod  <= PROD_W'(rd_budget) * PROD_W'(SCALE);
            state <= S_CHK_START;
          end
        end
        S_CHK_START: begin
          state <= S_CHK_WAIT;
        end
        S_CHK_WAIT: begin
          if (div_st.done) begin
            res_util <= res_util + UTIL_W'(div_q);
            idx      <= idx + CNT_W'(1);
            state    <= S_CHK_MUL;
          end
        end
        S_CHK_FIN: begin
          res_bound  <= bound_now;
          res_rm_ok  <= res_util <= UTIL_W'(bound_now);
          res_edf_ok <= res_util <= UTIL_W'(SCALE);
          state      <= S_RESULT;
        end
        S_RESULT: begin
          // load the output register once the previous word is gone
          if (!out_valid || out_ready) begin
            status            <= res_status;
            slot_out          <= res_slot;
            release_at        <= res_release;
            absolute_deadline <= res_abs;
            misses            <= res_misses;
            utilization       <= res_util;
            rm_bound          <= res_bound;
            rm_ok             <= res_rm_ok;
            edf_ok            <= res_edf_ok;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the divider is never left running across requests
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_st.busy)
    else $error("divider busy while taking a new word");

  // a divide result only arrives while the check waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_CHK_WAIT)
    else $error("divider result outside check wait");

  // a register on a full table leaves the task count alone
  a_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_REGISTER && !has_room
      |=> task_count == $past(task_count))
    else $error("task count changed on full table");

endmodule

### src/ptdm_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on ptdm_pkg for widths and the status struct
`timescale 1ns / 1ps

module ptdm_div
  import ptdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic [PROD_W-1:0] quotient,
  output div_status_t       st
);

  localparam int STEP_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [TIME_W:0]   shifted;
  logic              fits;

  assign shifted = {rem, quo[PROD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        steps <= STEP_W'(PROD_W);
        busy  <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= TIME_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[TIME_W-1:0];
        end
        quo   <= {quo[PROD_W-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign st.busy  = busy;
  assign st.done  = done;

endmodule

### bench/task_table_checker.sv
// reply checker for the periodic task deadline monitor: keeps its own task table,
// predicts every reply word and compares it field by field; depends on ptdm_pkg
`timescale 1ns / 1ps

module task_table_checker
  import ptdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [1:0]         task_slot,
  input  logic [TIME_W-1:0]  now_tick,
  input  logic [TIME_W-1:0]  period,
  input  logic [TIME_W-1:0]  relative_deadline,
  input  logic [TIME_W-1:0]  exec_budget,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [1:0]         slot_out,
  input  logic [TIME_W-1:0]  release_at,
  input  logic [TIME_W-1:0]  absolute_deadline,
  input  logic [TIME_W-1:0]  misses,
  input  logic [UTIL_W-1:0]  utilization,
  input  logic [BOUND_W-1:0] rm_bound,
  input  logic               rm_ok,
  input  logic               edf_ok,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         slot;
    logic [TIME_W-1:0]  release_at;
    logic [TIME_W-1:0]  deadline_at;
    logic [TIME_W-1:0]  misses;
    logic [UTIL_W-1:0]  util;
    logic [BOUND_W-1:0] bound;
    logic               rm_ok;
    logic               edf_ok;
  } reply_t;

  localparam int SLOTS = 4;
  localparam logic [BOUND_W-1:0] LL_BOUND [0:SLOTS] =
    '{14'd0, 14'd10000, 14'd8284, 14'd7798, 14'd7568};

  logic [2:0]        n_tasks;
  logic [TIME_W-1:0] tab_period   [SLOTS];
  logic [TIME_W-1:0] tab_deadline [SLOTS];
  logic [TIME_W-1:0] tab_budget   [SLOTS];
  logic [TIME_W-1:0] tab_release  [SLOTS];
  logic [TIME_W-1:0] tab_misses   [SLOTS];
  reply_t            expected_replies [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [TIME_W-1:0] misses_of(input logic [1:0] s);
    return (s < n_tasks) ? tab_misses[s] : '0;
  endfunction

  // applies one request to the table and returns the reply it must produce
  function automatic reply_t predict_request(input logic [1:0] md, input logic [1:0] s,
      input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] per,
      input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] bud);
    reply_t            r;
    logic [TIME_W-1:0] due;
    logic [63:0]       u;
    int                i;
    r = '0;
    r.slot = s;
    case (md)
      MODE_REGISTER: begin
        if (n_tasks >= SLOTS) begin
          r.status = ST_FULL;
          r.misses = misses_of(s);
        end else if (per == '0) begin
          r.status = ST_ZERO_PER;
          r.misses = misses_of(s);
        end else begin
          tab_period[n_tasks[1:0]]   = per;
          tab_deadline[n_tasks[1:0]] = dl;
          tab_budget[n_tasks[1:0]]   = bud;
          tab_release[n_tasks[1:0]]  = now + per;
          tab_misses[n_tasks[1:0]]   = '0;
          r.slot         = n_tasks[1:0];
          r.release_at   = now + per;
          r.deadline_at  = now + per + dl;
          n_tasks        = n_tasks + 3'd1;
        end
      end
      MODE_RELEASE: begin
        if (s >= n_tasks) begin
          r.status = ST_UNREG;
        end else begin
          due = tab_release[s] - tab_period[s] + tab_deadline[s];
          if (now > due) tab_misses[s] = tab_misses[s] + 1;
          r.release_at   = tab_release[s];
          r.deadline_at  = tab_release[s] + tab_deadline[s];
          r.misses       = tab_misses[s];
          tab_release[s] = tab_release[s] + tab_period[s];
        end
      end
      MODE_CHECK: begin
        u = '0;
        for (i = 0; i < SLOTS; i++)
          if (i < n_tasks)
            u += (64'(tab_budget[2'(i)]) * SCALE) / 64'(tab_period[2'(i)]);
        r.misses = misses_of(s);
        r.util   = u[UTIL_W-1:0];
        r.bound  = LL_BOUND[n_tasks];
        r.rm_ok  = (u <= 64'(r.bound));
        r.edf_ok = (u <= 64'(SCALE));
      end
      default: r.misses = misses_of(s);
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      n_tasks = '0;
      expected_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply word with no request waiting");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("slot_out", 64'(want.slot), 64'(slot_out));
          check_field("release_at", 64'(want.release_at), 64'(release_at));
          check_field("absolute_deadline", 64'(want.deadline_at),
                      64'(absolute_deadline));
          check_field("misses", 64'(want.misses), 64'(misses));
          check_field("utilization", 64'(want.util), 64'(utilization));
          check_field("rm_bound", 64'(want.bound), 64'(rm_bound));
          check_field("rm_ok", 64'(want.rm_ok), 64'(rm_ok));
          check_field("edf_ok", 64'(want.edf_ok), 64'(edf_ok));
        end
      end
      if (in_valid && in_ready)
        expected_replies.push_back(predict_request(mode, task_slot, now_tick, period,
                                                   relative_deadline, exec_budget));
    end
    pending <= expected_replies.size();
  end

endmodule

### bench/tb_top.sv
// testbench top for the periodic task deadline monitor: clock, reset, request and
// reply handshakes, verdict; depends on ptdm_pkg, the dut and task_table_checker
`timescale 1ns / 1ps

module tb_top;
  import ptdm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // no operation, only reports misses

  localparam int RANDOM_WORDS = 1530;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_AFTER   = 300;        // reply count at which the long hold starts
  localparam int HOLD_CYCLES  = 400;
  localparam int PAUSE_AT     = 700;        // request index after which the sender drains

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         mode;
  logic [1:0]         task_slot;
  logic [TIME_W-1:0]  now_tick;
  logic [TIME_W-1:0]  period;
  logic [TIME_W-1:0]  relative_deadline;
  logic [TIME_W-1:0]  exec_budget;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [1:0]         slot_out;
  logic [TIME_W-1:0]  release_at;
  logic [TIME_W-1:0]  absolute_deadline;
  logic [TIME_W-1:0]  misses;
  logic [UTIL_W-1:0]  utilization;
  logic [BOUND_W-1:0] rm_bound;
  logic               rm_ok;
  logic               edf_ok;
  int                 fail_count;
  int                 pending;
  int                 cycles;

  // sender's own view of the table, only used to aim now_tick near deadlines
  int unsigned        n_booked;
  logic [TIME_W-1:0]  book_period   [4];
  logic [TIME_W-1:0]  book_deadline [4];
  logic [TIME_W-1:0]  book_release  [4];

  // burst flags give stretches with no idling on either side
  bit                 send_burst = 1'b0;
  bit                 take_burst = 1'b0;
  int                 taken = 0;

  periodic_task_deadline_monitor #(.MAX_TASKS(4)) dut (.*);

  task_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // tick at which the current instance of a booked task hits its deadline, plus offset
  function automatic logic [TIME_W-1:0] aim_at_deadline(input logic [1:0] s,
      input int off);
    return book_release[s] - book_period[s] + book_deadline[s] + off;
  endfunction

  // mostly around the deadline so both sides of the miss test are hit
  function automatic logic [TIME_W-1:0] release_tick(input logic [1:0] s);
    case ($urandom_range(0, 5))
      0:       return aim_at_deadline(s, -1);
      1:       return aim_at_deadline(s, 0);
      2:       return aim_at_deadline(s, 1);
      3:       return aim_at_deadline(s, int'($urandom_range(0, 2000)) - 1000);
      4:       return $urandom();
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  // offers one request word, returns after it is taken and the idle gap has passed
  task automatic offer(input logic [1:0] md, input logic [1:0] s,
      input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] per,
      input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] bud);
    int gap;
    in_valid          <= 1'b1;
    mode              <= md;
    task_slot         <= s;
    now_tick          <= now;
    period            <= per;
    relative_deadline <= dl;
    exec_budget       <= bud;
    do @(posedge clk); while (!in_ready);
    // follow successful bookings and releases on the sender side
    if (md == MODE_REGISTER && n_booked < 4 && per != '0) begin
      book_period[2'(n_booked)]   = per;
      book_deadline[2'(n_booked)] = dl;
      book_release[2'(n_booked)]  = now + per;
      n_booked++;
    end else if (md == MODE_RELEASE && s < n_booked) begin
      book_release[s] = book_release[s] + book_period[s];
    end
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // request side: reset, directed words, random words, drain, verdict
  initial begin
    int         n;
    int         pick;
    logic [1:0] s;
    rst               = 1'b1;
    in_valid          = 1'b0;
    mode              = MODE_REGISTER;
    task_slot         = '0;
    now_tick          = '0;
    period            = '0;
    relative_deadline = '0;
    exec_budget       = '0;
    n_booked          = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table: check, no-op, release of an unbooked slot, zero period
    offer(MODE_CHECK, 2'd0, $urandom(), $urandom(), $urandom(), $urandom());
    offer(MODE_UNUSED, 2'd3, $urandom(), $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd0, $urandom(), $urandom(), $urandom(), $urandom());
    offer(MODE_REGISTER, 2'd2, $urandom(), '0, $urandom(), $urandom());
    // slot 0: first release wraps to zero, utilization exactly at both bounds
    offer(MODE_REGISTER, 2'd1, '1, 32'd1, '0, 32'd1);
    offer(MODE_CHECK, 2'd0, $urandom(), $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd0, '0, $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd0, '1, $urandom(), $urandom(), $urandom());
    // slot 1: largest period and deadline, zero budget
    offer(MODE_REGISTER, 2'd3, $urandom(), '1, '1, '0);
    offer(MODE_CHECK, 2'd1, $urandom(), $urandom(), $urandom(), $urandom());
    // slot 2: release time wraps past the top of the tick range
    offer(MODE_REGISTER, 2'd0, 32'hFFFF_FFE0, 32'h30, 32'h10, 32'h7);
    offer(MODE_CHECK, 2'd2, $urandom(), $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd3, $urandom(), $urandom(), $urandom(), $urandom());
    // slot 3: largest budget on the shortest period, utilization far over
    offer(MODE_REGISTER, 2'd2, '0, 32'd1, 32'd5, '1);
    offer(MODE_CHECK, 2'd3, $urandom(), $urandom(), $urandom(), $urandom());
    // full table wins over zero period
    offer(MODE_REGISTER, 2'd0, $urandom(), '0, $urandom(), $urandom());
    offer(MODE_REGISTER, 2'd1, $urandom(), '1, '1, '1);
    offer(MODE_UNUSED, 2'd1, $urandom(), $urandom(), $urandom(), $urandom());
    // miss test on the boundary, just past it and just before it
    offer(MODE_RELEASE, 2'd2, aim_at_deadline(2'd2, 0), $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd2, aim_at_deadline(2'd2, 1), $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd1, aim_at_deadline(2'd1, -1), $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd3, '1, $urandom(), $urandom(), $urandom());
    offer(MODE_RELEASE, 2'd0, '0, $urandom(), $urandom(), $urandom());

    // random part: mostly releases on booked tasks, then checks, no-ops and
    // register attempts against the full table
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      s    = 2'($urandom_range(0, 3));
      if (pick < 60)
        offer(MODE_RELEASE, s, release_tick(s), $urandom(), $urandom(), $urandom());
      else if (pick < 72)
        offer(MODE_CHECK, s, $urandom(), $urandom(), $urandom(), $urandom());
      else if (pick < 82)
        offer(MODE_UNUSED, s, $urandom(), $urandom(), $urandom(), $urandom());
      else
        offer(MODE_REGISTER, s, $urandom(),
              ($urandom_range(0, 3) == 0) ? '0 : $urandom(), $urandom(), $urandom());
      // sender waits once until every reply word is back
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // reply side: random stalls per word, one long hold that backs up the dut
  initial begin : reply_taker
    int stall;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken == HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

### periodic_task_deadline_monitor.f
src/ptdm_pkg.sv
src/ptdm_div.sv
src/periodic_task_deadline_monitor.sv
bench/task_table_checker.sv
bench/tb_top.sv
